### hw/rtl/stet_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timed event table - shared definitions
// Opcodes, status codes, the stored entry and the command broadcast to the
// row of table cells.
// ----------------------------------------------------------------------------
package stet_pkg;

   // default number of table cells
   localparam int DEFAULT_DEPTH = 256;

   // request opcodes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_RANGE  = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_INDEX = 2'd2;

   // one stored event
   typedef struct packed {
      logic [31:0] beat_time;
      logic [23:0] message;
      logic [1:0]  msg_length;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic        do_insert;
      logic        do_remove;
      logic        collect_clear;
      logic [31:0] start_time;
      logic [31:0] end_time;
      entry_type   new_entry;
   } cmd_type;

endpackage

### hw/rtl/stet_cell.sv
// ----------------------------------------------------------------------------
// Sorted timed event table - cell
// Holds one table entry, shifts with its neighbours on insert and remove,
// and passes a collect word towards cell 0 for read and range queries.
// ----------------------------------------------------------------------------
module stet_cell #(
   parameter int CELL_INDEX = 0,
   parameter int COUNT_W    = 9
) (
   input  logic                clock,
   input  stet_pkg::cmd_type   cmd,
   input  logic [COUNT_W-1:0]  count,
   input  logic [COUNT_W-1:0]  index,
   input  stet_pkg::entry_type left_entry,
   input  stet_pkg::entry_type right_entry,
   input  logic                left_ge_start,
   input  logic                left_ge_end,
   output logic                ge_start,
   output logic                ge_end,
   output stet_pkg::entry_type entry,
   input  stet_pkg::entry_type right_read,
   input  logic [COUNT_W-1:0]  right_first_pos,
   input  logic [COUNT_W-1:0]  right_end_pos,
   input  logic                right_first_hit,
   input  logic                right_end_hit,
   output stet_pkg::entry_type collect_read,
   output logic [COUNT_W-1:0]  collect_first_pos,
   output logic [COUNT_W-1:0]  collect_end_pos,
   output logic                collect_first_hit,
   output logic                collect_end_hit
);
   import stet_pkg::*;

   localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(CELL_INDEX);

   entry_type          entry_ff, entry_in;
   entry_type          read_ff, read_in;
   logic [COUNT_W-1:0] first_pos_ff, first_pos_in;
   logic [COUNT_W-1:0] end_pos_ff, end_pos_in;
   logic               first_hit_ff, first_hit_in;
   logic               end_hit_ff, end_hit_in;

   logic valid;
   logic bound_start;
   logic bound_end;

   // compare against the broadcast times; empty cells count as "at least"
   always_comb begin
      valid       = MY_INDEX < count;
      ge_start    = !valid || (entry_ff.beat_time >= cmd.start_time);
      ge_end      = !valid || (entry_ff.beat_time >= cmd.end_time);
      bound_start = ge_start && !left_ge_start;
      bound_end   = ge_end && !left_ge_end;
   end

   // shift the entry for insert and remove, else hold
   always_comb begin
      entry_in = entry_ff;
      if (cmd.do_insert) begin
         if (bound_start) begin
            entry_in = cmd.new_entry;
         end else if (ge_start && left_ge_start) begin
            entry_in = left_entry;
         end
      end else if (cmd.do_remove) begin
         if (MY_INDEX >= index) begin
            entry_in = right_entry;
         end
      end
   end

   // merge own contribution into the word arriving from the right
   always_comb begin
      if (cmd.collect_clear) begin
         read_in      = '0;
         first_pos_in = '0;
         end_pos_in   = '0;
         first_hit_in = 1'b0;
         end_hit_in   = 1'b0;
      end else begin
         read_in      = right_read | ((MY_INDEX == index) ? entry_ff : '0);
         first_pos_in = right_first_pos | (bound_start ? MY_INDEX : '0);
         end_pos_in   = right_end_pos | (bound_end ? MY_INDEX : '0);
         first_hit_in = right_first_hit | bound_start;
         end_hit_in   = right_end_hit | bound_end;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      read_ff      <= read_in;
      first_pos_ff <= first_pos_in;
      end_pos_ff   <= end_pos_in;
      first_hit_ff <= first_hit_in;
      end_hit_ff   <= end_hit_in;
   end

   assign entry             = entry_ff;
   assign collect_read      = read_ff;
   assign collect_first_pos = first_pos_ff;
   assign collect_end_pos   = end_pos_ff;
   assign collect_first_hit = first_hit_ff;
   assign collect_end_hit   = end_hit_ff;

endmodule

### hw/rtl/sorted_timed_event_table.sv
// ----------------------------------------------------------------------------
// Sorted timed event table
// Time-ordered event table built as a row of cells that shift on insert and
// remove and drain a collect word towards cell 0 for read and range queries.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one word per operation, opcode in req_tuser. rsp channel:
//   exactly one word per request, status in rsp_tuser.
//   One request is in work at a time; req_tready is high while the
//   sequencer is idle.
//   Insert, remove, clear and unknown opcodes: the request is registered,
//   then the execute state writes the response once the output slot is free.
//   Read and range: the collect word walks from cell to cell towards cell 0,
//   one cell a cycle, and the response is written once the step counter has
//   covered the stored events and the output slot is free.
//   A finished response waits in the output register; while it is not taken
//   the next request is still accepted and worked on up to the point where
//   its own response would be written.
//   Reset empties the table at once; no clearing pass is needed because only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_timed_event_table #(
   parameter int TABLE_DEPTH = stet_pkg::DEFAULT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_beats[31:0], message_bytes[55:32], message_length[57:56],
   // entry_index[65:58], range_end[97:66], zero padding[103:98]
   input  logic [103:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0]   req_tuser,
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_count[8:0], read_time[40:9], read_message[64:41],
   // read_length[66:65], first_position[75:67], end_position[84:76],
   // zero padding[87:85]
   output logic [87:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);
   import stet_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = $clog2(TABLE_DEPTH + 2);
   localparam int WW = CW + 9;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COLLECT} state_type;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   entry_type   key_ff, key_in;
   logic [31:0] end_ff, end_in;
   logic [7:0]  idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [8:0]  rsp_count_ff, rsp_count_in;
   entry_type   rsp_read_ff, rsp_read_in;
   logic [8:0]  rsp_first_ff, rsp_first_in;
   logic [8:0]  rsp_end_ff, rsp_end_in;

   cmd_type     cmd;
   logic        req_fire;
   logic        slot_free;
   logic        index_bad;
   logic        table_full;
   logic        is_query;
   logic        step_done;
   logic [WW-1:0] idx_wide;
   logic [WW-1:0] count_wide;
   logic [WW-1:0] count_in_wide;
   logic [WW-1:0] first_wide;
   logic [WW-1:0] end_wide;
   logic [CW-1:0] cell_index;
   logic [CW-1:0] first_full;
   logic [CW-1:0] end_raw;
   logic [CW-1:0] end_full;

   // cell row wiring; the extra slot at the right end feeds zeros
   entry_type     entry_w     [TABLE_DEPTH+1];
   entry_type     read_w      [TABLE_DEPTH+1];
   logic [CW-1:0] first_pos_w [TABLE_DEPTH+1];
   logic [CW-1:0] end_pos_w   [TABLE_DEPTH+1];
   logic          first_hit_w [TABLE_DEPTH+1];
   logic          end_hit_w   [TABLE_DEPTH+1];
   logic          ge_start_w  [TABLE_DEPTH];
   logic          ge_end_w    [TABLE_DEPTH];

   assign entry_w[TABLE_DEPTH]     = '0;
   assign read_w[TABLE_DEPTH]      = '0;
   assign first_pos_w[TABLE_DEPTH] = '0;
   assign end_pos_w[TABLE_DEPTH]   = '0;
   assign first_hit_w[TABLE_DEPTH] = 1'b0;
   assign end_hit_w[TABLE_DEPTH]   = 1'b0;

   // decode shared conditions
   always_comb begin
      req_fire   = req_tvalid && req_tready;
      slot_free  = !rsp_valid_ff || rsp_tready;
      idx_wide   = WW'(idx_ff);
      count_wide = WW'(count_ff);
      index_bad  = idx_wide >= count_wide;
      cell_index = idx_wide[CW-1:0];
      table_full = count_ff == FULL_COUNT;
      is_query   = (op_ff == OP_READ) || (op_ff == OP_RANGE);
      step_done  = step_ff == (SW'(count_ff) + SW'(1));
      first_full = first_hit_w[0] ? first_pos_w[0] : count_ff;
      end_raw    = end_hit_w[0] ? end_pos_w[0] : count_ff;
      end_full   = (end_raw > first_full) ? end_raw : first_full;
      first_wide = WW'(first_full);
      end_wide   = WW'(end_full);
   end

   // sequence one request at a time
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      end_in        = end_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      cmd           = '0;
      cmd.start_time = key_ff.beat_time;
      cmd.end_time   = end_ff;
      cmd.new_entry  = key_ff;
      count_in_wide  = WW'(count_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in                = req_tuser;
               key_in.beat_time     = req_tdata[31:0];
               key_in.message       = req_tdata[55:32];
               key_in.msg_length    = req_tdata[57:56];
               idx_in               = req_tdata[65:58];
               end_in               = req_tdata[97:66];
               state_in             = S_EXEC;
            end
         end
         S_EXEC: begin
            if (is_query) begin
               // clear the collect words, then let them drain
               cmd.collect_clear = 1'b1;
               step_in           = '0;
               state_in          = S_COLLECT;
            end else if (slot_free) begin
               rsp_status_in = ST_OK;
               rsp_read_in   = '0;
               rsp_first_in  = '0;
               rsp_end_in    = '0;
               case (op_ff)
                  OP_INSERT: begin
                     if (table_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cmd.do_insert = 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (index_bad) begin
                        rsp_status_in = ST_BAD_INDEX;
                     end else begin
                        cmd.do_remove = 1'b1;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               count_in_wide = WW'(count_in);
               rsp_count_in  = count_in_wide[8:0];
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_COLLECT: begin
            if (!step_done) begin
               step_in = step_ff + 1'b1;
            end else if (slot_free) begin
               rsp_status_in = ST_OK;
               rsp_count_in  = count_wide[8:0];
               rsp_read_in   = '0;
               rsp_first_in  = '0;
               rsp_end_in    = '0;
               if (op_ff == OP_READ) begin
                  if (index_bad) begin
                     rsp_status_in = ST_BAD_INDEX;
                  end else begin
                     rsp_read_in = read_w[0];
                  end
               end else begin
                  rsp_first_in = first_wide[8:0];
                  rsp_end_in   = end_wide[8:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      end_ff        <= end_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // row of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_ge_start;
      logic      left_ge_end;

      if (i == 0) begin : g_first
         assign left_entry    = '0;
         assign left_ge_start = 1'b0;
         assign left_ge_end   = 1'b0;
      end else begin : g_rest
         assign left_entry    = entry_w[i-1];
         assign left_ge_start = ge_start_w[i-1];
         assign left_ge_end   = ge_end_w[i-1];
      end

      stet_cell #(
         .CELL_INDEX (i),
         .COUNT_W    (CW)
      ) u_cell (
         .clock             (clock),
         .cmd               (cmd),
         .count             (count_ff),
         .index             (cell_index),
         .left_entry        (left_entry),
         .right_entry       (entry_w[i+1]),
         .left_ge_start     (left_ge_start),
         .left_ge_end       (left_ge_end),
         .ge_start          (ge_start_w[i]),
         .ge_end            (ge_end_w[i]),
         .entry             (entry_w[i]),
         .right_read        (read_w[i+1]),
         .right_first_pos   (first_pos_w[i+1]),
         .right_end_pos     (end_pos_w[i+1]),
         .right_first_hit   (first_hit_w[i+1]),
         .right_end_hit     (end_hit_w[i+1]),
         .collect_read      (read_w[i]),
         .collect_first_pos (first_pos_w[i]),
         .collect_end_pos   (end_pos_w[i]),
         .collect_first_hit (first_hit_w[i]),
         .collect_end_hit   (end_hit_w[i])
      );
   end

   // drive the ports
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_end_ff, rsp_first_ff, rsp_read_ff.msg_length,
                        rsp_read_ff.message, rsp_read_ff.beat_time, rsp_count_ff};

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above table depth");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_EXEC)
      else $error("accepted request did not start work");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the count");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COLLECT |-> step_ff <= (SW'(count_ff) + SW'(1)))
      else $error("collect step overran the stored count");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |->
         (rsp_read_ff == '0 && rsp_first_ff == '0 && rsp_end_ff == '0))
      else $error("failed operation returned data");
`endif

endmodule
